@@ src/fbpwa_pkg.sv @@
// Shared types and constants of the framebuffer pixel write address unit.
package fbpwa_pkg;

   localparam int unsigned AddrBitsDefault  = 24;
   localparam int unsigned MaxPlanesDefault = 8;

   localparam int unsigned CsrAddrWidth = 5;
   localparam int unsigned CsrDataWidth = 32;

   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 56;
   localparam int unsigned RspUserWidth = 2;

   localparam int unsigned CoordWidth  = 11;
   localparam int unsigned ColorWidth  = 8;
   localparam int unsigned OffsetWidth = 24;

   // Reciprocal for y / 3 on 11-bit rows: (y * 683) >> 11, corrected down by one.
   localparam logic [9:0] DivThreeRecip = 10'd683;
   localparam int unsigned DivThreeShift = 11;

   localparam logic [1:0] TwoBitMask = 2'h3;
   localparam logic [7:0] LeftBit    = 8'h80;

   typedef enum logic [2:0] {
      REG_ENABLED         = 3'd0,
      REG_MEMORY_LAYOUT   = 3'd1,
      REG_SCREEN_WIDTH    = 3'd2,
      REG_SCREEN_HEIGHT   = 3'd3,
      REG_ROW_PITCH       = 3'd4,
      REG_ODD_BANK_OFFSET = 3'd5,
      REG_BANK_INTERLEAVE = 3'd6,
      REG_PLANE_COUNT     = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      LAYOUT_LINEAR      = 2'd0,
      LAYOUT_INTERLEAVED = 2'd1,
      LAYOUT_PLANAR      = 2'd2,
      LAYOUT_BANKED      = 2'd3
   } layout_type;

   typedef enum logic [1:0] {
      STATUS_WRITE       = 2'd0,
      STATUS_OUTSIDE     = 2'd1,
      STATUS_NOT_ENABLED = 2'd2,
      STATUS_UNUSED      = 2'd3
   } status_type;

   // Middle stage: everything but the row * pitch product.
   typedef struct packed {
      status_type             status;
      logic [CoordWidth-1:0]  row;
      logic [CoordWidth-1:0]  col_term;
      logic [15:0]            base;
      logic [7:0]             bit_mask;
      logic [7:0]             write_bits;
      logic [7:0]             plane_enable;
      logic [7:0]             plane_set;
   } mid_type;

endpackage

@@ src/framebuffer_pixel_write_address_unit.sv @@
// Top level of the framebuffer pixel write address unit.
//
// Turns one pixel write (x, y, color index) into one masked byte write to
// video memory: a byte offset from the framebuffer base, a bit mask, the new
// bits, and the plane enable / plane set masks for planar layouts.
// Channels: req_ stream in (one transaction per pixel), rsp_ stream out (one
// transaction per pixel, in order), csr_ APB-style port for the eight mode
// registers at byte addresses 0x00..0x1C.
// Throughput: one pixel per cycle while rsp_tready is high. Each request passes
// through the input register, the decode register and the multiply/add register,
// in that order, before rsp_tvalid rises for it.
// The row * pitch product is one 11x13 multiply in the last stage; the
// interleave divide by three is a reciprocal multiply in the decode stage.
// When rsp_tready is low the pipeline holds; empty stages still fill, so up
// to three transactions are held before req_tready drops.
// Reset (synchronous, active high) empties the pipeline and returns the
// registers to their defaults; the block then reports "not enabled" for
// every pixel until the enabled register is written with one.
// Registers are to be written only while the pipeline is empty.
module framebuffer_pixel_write_address_unit #(
   parameter int unsigned ADDR_BITS  = fbpwa_pkg::AddrBitsDefault,
   parameter int unsigned MAX_PLANES = fbpwa_pkg::MaxPlanesDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // tdata: pixel_x [10:0], pixel_y [21:11], color_index [29:22], zero [31:30]
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [fbpwa_pkg::ReqDataWidth-1:0]   req_tdata,
   // tdata: byte_offset [23:0], bit_mask [31:24], write_bits [39:32],
   //        plane_enable [47:40], plane_set [55:48]
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [fbpwa_pkg::RspDataWidth-1:0]   rsp_tdata,
   // tuser: status [1:0]
   output logic [fbpwa_pkg::RspUserWidth-1:0]   rsp_tuser,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [fbpwa_pkg::CsrAddrWidth-1:0]   csr_paddr,
   input  logic [fbpwa_pkg::CsrDataWidth-1:0]   csr_pwdata,
   output logic [fbpwa_pkg::CsrDataWidth-1:0]   csr_prdata,
   output logic                                 csr_pready
);

   localparam logic [fbpwa_pkg::OffsetWidth-1:0] OffsetMask =
      (ADDR_BITS >= fbpwa_pkg::OffsetWidth) ? {fbpwa_pkg::OffsetWidth{1'b1}} :
      fbpwa_pkg::OffsetWidth'((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [3:0] MaxPlanesCode = 4'(MAX_PLANES);

   // ---------------- configuration registers ----------------
   logic                       enabled_ff;
   fbpwa_pkg::layout_type      layout_ff;
   logic [11:0]                width_ff;
   logic [11:0]                height_ff;
   logic [12:0]                pitch_ff;
   logic [15:0]                odd_bank_ff;
   logic [1:0]                 interleave_ff;
   logic [3:0]                 plane_count_ff;

   logic                       csr_write;
   fbpwa_pkg::reg_index_type   csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = fbpwa_pkg::reg_index_type'(csr_paddr[4:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff     <= 1'b0;
         layout_ff      <= fbpwa_pkg::LAYOUT_LINEAR;
         width_ff       <= 12'd320;
         height_ff      <= 12'd200;
         pitch_ff       <= 13'd320;
         odd_bank_ff    <= 16'd8192;
         interleave_ff  <= 2'd2;
         plane_count_ff <= 4'd4;
      end else if (csr_write) begin
         case (csr_index)
            fbpwa_pkg::REG_ENABLED:         enabled_ff     <= csr_pwdata[0];
            fbpwa_pkg::REG_MEMORY_LAYOUT:
               layout_ff <= fbpwa_pkg::layout_type'(csr_pwdata[1:0]);
            fbpwa_pkg::REG_SCREEN_WIDTH:    width_ff       <= csr_pwdata[11:0];
            fbpwa_pkg::REG_SCREEN_HEIGHT:   height_ff      <= csr_pwdata[11:0];
            fbpwa_pkg::REG_ROW_PITCH:       pitch_ff       <= csr_pwdata[12:0];
            fbpwa_pkg::REG_ODD_BANK_OFFSET: odd_bank_ff    <= csr_pwdata[15:0];
            fbpwa_pkg::REG_BANK_INTERLEAVE: interleave_ff  <= csr_pwdata[1:0];
            fbpwa_pkg::REG_PLANE_COUNT:     plane_count_ff <= csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         fbpwa_pkg::REG_ENABLED:         csr_prdata = {31'd0, enabled_ff};
         fbpwa_pkg::REG_MEMORY_LAYOUT:   csr_prdata = {30'd0, layout_ff};
         fbpwa_pkg::REG_SCREEN_WIDTH:    csr_prdata = {20'd0, width_ff};
         fbpwa_pkg::REG_SCREEN_HEIGHT:   csr_prdata = {20'd0, height_ff};
         fbpwa_pkg::REG_ROW_PITCH:       csr_prdata = {19'd0, pitch_ff};
         fbpwa_pkg::REG_ODD_BANK_OFFSET: csr_prdata = {16'd0, odd_bank_ff};
         fbpwa_pkg::REG_BANK_INTERLEAVE: csr_prdata = {30'd0, interleave_ff};
         fbpwa_pkg::REG_PLANE_COUNT:     csr_prdata = {28'd0, plane_count_ff};
         default:                        csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline handshake ----------------
   // Each stage loads when it is empty or its contents move on this cycle.
   logic in_valid_ff, mid_valid_ff, out_valid_ff;
   logic out_load, mid_load, in_load;

   assign out_load   = !out_valid_ff || rsp_tready;
   assign mid_load   = !mid_valid_ff || out_load;
   assign in_load    = !in_valid_ff  || mid_load;
   assign req_tready = in_load;
   assign rsp_tvalid = out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_load)  in_valid_ff  <= req_tvalid;
         if (mid_load) mid_valid_ff <= in_valid_ff;
         if (out_load) out_valid_ff <= mid_valid_ff;
      end
   end

   // ---------------- stage 1: input register ----------------
   logic [10:0] x_ff, y_ff;
   logic [7:0]  color_ff;

   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         x_ff     <= req_tdata[10:0];
         y_ff     <= req_tdata[21:11];
         color_ff <= req_tdata[29:22];
      end
   end

   // ---------------- stage 2: decode ----------------
   logic [21:0]        div3_prod;
   logic [10:0]        div3_est;
   logic [12:0]        div3_back;
   logic [10:0]        div3_row;
   logic [10:0]        inter_row;
   logic [2:0]         two_bit_shift;
   logic [3:0]         plane_n;
   logic [7:0]         plane_mask;
   fbpwa_pkg::mid_type mid_in, mid_ff;

   // y / 3 by reciprocal; the estimate is never low, at most one high.
   assign div3_prod = 22'(y_ff) * 22'(fbpwa_pkg::DivThreeRecip);
   assign div3_est  = div3_prod[fbpwa_pkg::DivThreeShift +: 11];
   assign div3_back = {1'b0, div3_est, 1'b0} + {2'b00, div3_est};
   assign div3_row  = (div3_back > {2'b00, y_ff}) ? div3_est - 11'd1 : div3_est;

   always_comb begin
      case (interleave_ff)
         2'd2:    inter_row = {1'b0, y_ff[10:1]};
         2'd3:    inter_row = div3_row;
         default: inter_row = y_ff;          // zero acts as one
      endcase
   end

   // leftmost pixel in the top bits: shift = (3 - x%4) * 2
   assign two_bit_shift = {~x_ff[1:0], 1'b0};

   assign plane_n = (plane_count_ff > MaxPlanesCode) ? MaxPlanesCode : plane_count_ff;
   always_comb begin
      for (int p = 0; p < 8; p++) begin
         plane_mask[p] = (4'(p) < plane_n);
      end
   end

   always_comb begin
      mid_in = '0;
      if (!enabled_ff) begin
         mid_in.status = fbpwa_pkg::STATUS_NOT_ENABLED;
      end else if ({1'b0, x_ff} >= width_ff || {1'b0, y_ff} >= height_ff) begin
         mid_in.status = fbpwa_pkg::STATUS_OUTSIDE;
      end else begin
         mid_in.status = fbpwa_pkg::STATUS_WRITE;
         case (layout_ff)
            fbpwa_pkg::LAYOUT_INTERLEAVED: begin
               mid_in.row          = inter_row;
               mid_in.col_term     = {2'b00, x_ff[10:2]};
               mid_in.base         = y_ff[0] ? odd_bank_ff : 16'd0;
               mid_in.bit_mask     = 8'({6'd0, fbpwa_pkg::TwoBitMask} << two_bit_shift);
               mid_in.write_bits   = 8'({6'd0, color_ff[1:0]} << two_bit_shift);
               mid_in.plane_enable = 8'd1;
            end
            fbpwa_pkg::LAYOUT_PLANAR: begin
               mid_in.row          = y_ff;
               mid_in.col_term     = {3'b000, x_ff[10:3]};
               mid_in.bit_mask     = fbpwa_pkg::LeftBit >> x_ff[2:0];
               mid_in.plane_enable = plane_mask;
               mid_in.plane_set    = color_ff & plane_mask;
            end
            default: begin                   // linear and banked
               mid_in.row          = y_ff;
               mid_in.col_term     = x_ff;
               mid_in.bit_mask     = 8'hFF;
               mid_in.write_bits   = color_ff;
               mid_in.plane_enable = 8'd1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mid_load && in_valid_ff) begin
         mid_ff <= mid_in;
      end
   end

   // ---------------- stage 3: row * pitch and offset sum ----------------
   logic [23:0]            row_prod;
   logic [25:0]            offset_sum;
   logic [23:0]            offset_in, offset_ff;
   fbpwa_pkg::status_type  status_ff;
   logic [7:0]             mask_ff, bits_ff, pen_ff, pset_ff;

   assign row_prod   = 24'(mid_ff.row) * 24'(pitch_ff);
   assign offset_sum = {2'b00, row_prod} + {10'd0, mid_ff.base}
                     + {15'd0, mid_ff.col_term};
   assign offset_in  = offset_sum[23:0] & OffsetMask;

   always_ff @(posedge clock) begin
      if (out_load && mid_valid_ff) begin
         offset_ff <= offset_in;
         status_ff <= mid_ff.status;
         mask_ff   <= mid_ff.bit_mask;
         bits_ff   <= mid_ff.write_bits;
         pen_ff    <= mid_ff.plane_enable;
         pset_ff   <= mid_ff.plane_set;
      end
   end

   assign rsp_tdata = {pset_ff, pen_ff, bits_ff, mask_ff, offset_ff};
   assign rsp_tuser = status_ff;

endmodule

@@ sim/fbpwa_write_checker.sv @@
// Checker: predicts the masked byte write for every accepted pixel and compares responses.
`timescale 1ns / 1ps

module fbpwa_write_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [fbpwa_pkg::ReqDataWidth-1:0] req_tdata,
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [fbpwa_pkg::RspDataWidth-1:0] rsp_tdata,
   input  logic [fbpwa_pkg::RspUserWidth-1:0] rsp_tuser,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [fbpwa_pkg::CsrAddrWidth-1:0] csr_paddr,
   input  logic [fbpwa_pkg::CsrDataWidth-1:0] csr_pwdata,
   input  logic                               csr_pready,
   output int                                 fail_count,
   output int                                 pending,
   output int                                 checked
);

   localparam int unsigned AddrBits  = fbpwa_pkg::AddrBitsDefault;
   localparam int unsigned MaxPlanes = fbpwa_pkg::MaxPlanesDefault;

   typedef struct packed {
      fbpwa_pkg::status_type status;
      logic [23:0]           byte_offset;
      logic [7:0]            bit_mask;
      logic [7:0]            write_bits;
      logic [7:0]            plane_enable;
      logic [7:0]            plane_set;
   } pixel_write_type;

   // shadow of the mode registers
   logic                  mode_enabled;
   fbpwa_pkg::layout_type mode_layout;
   logic [11:0]           mode_width;
   logic [11:0]           mode_height;
   logic [12:0]           mode_pitch;
   logic [15:0]           mode_odd_bank;
   logic [1:0]            mode_interleave;
   logic [3:0]            mode_planes;

   pixel_write_type expected_writes[$];
   pixel_write_type oldest;

   initial begin
      fail_count = 0;
      checked    = 0;
      pending    = 0;
   end

   function automatic pixel_write_type pixel_write_for(logic [10:0] x, logic [10:0] y,
                                                       logic [7:0] color);
      pixel_write_type w;
      logic [63:0]     offset;
      int unsigned     divisor;
      int unsigned     shift;
      int unsigned     planes;
      w      = '0;
      offset = '0;
      if (!mode_enabled) begin
         w.status = fbpwa_pkg::STATUS_NOT_ENABLED;
      end else if ({1'b0, x} >= mode_width || {1'b0, y} >= mode_height) begin
         w.status = fbpwa_pkg::STATUS_OUTSIDE;
      end else begin
         w.status = fbpwa_pkg::STATUS_WRITE;
         case (mode_layout)
            fbpwa_pkg::LAYOUT_INTERLEAVED: begin
               divisor = (mode_interleave == 2'd0) ? 1 : int'(mode_interleave);
               shift   = (3 - int'(x[1:0])) * 2;
               offset  = (y[0] ? 64'(mode_odd_bank) : 64'd0)
                       + 64'(int'(y) / divisor) * 64'(mode_pitch) + 64'(x >> 2);
               w.bit_mask     = 8'({6'd0, fbpwa_pkg::TwoBitMask} << shift);
               w.write_bits   = 8'({6'd0, color[1:0]} << shift);
               w.plane_enable = 8'd1;
            end
            fbpwa_pkg::LAYOUT_PLANAR: begin
               planes = (mode_planes > MaxPlanes) ? MaxPlanes : int'(mode_planes);
               offset = 64'(y) * 64'(mode_pitch) + 64'(x >> 3);
               w.bit_mask     = fbpwa_pkg::LeftBit >> x[2:0];
               w.plane_enable = 8'((16'd1 << planes) - 16'd1);
               w.plane_set    = color & w.plane_enable;
            end
            default: begin
               // linear and banked share the byte-per-pixel layout
               offset = 64'(y) * 64'(mode_pitch) + 64'(x);
               w.bit_mask     = 8'hFF;
               w.write_bits   = color;
               w.plane_enable = 8'd1;
            end
         endcase
      end
      offset        = offset & ((64'd1 << AddrBits) - 64'd1);
      w.byte_offset = offset[23:0];
      return w;
   endfunction

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_enabled    <= 1'b0;
         mode_layout     <= fbpwa_pkg::LAYOUT_LINEAR;
         mode_width      <= 12'd320;
         mode_height     <= 12'd200;
         mode_pitch      <= 13'd320;
         mode_odd_bank   <= 16'd8192;
         mode_interleave <= 2'd2;
         mode_planes     <= 4'd4;
         expected_writes.delete();
         pending         <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_writes.push_back(pixel_write_for(req_tdata[10:0], req_tdata[21:11],
                                                      req_tdata[29:22]));
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_writes.size() == 0) begin
               $display("%0t: response without a pending pixel, actual tdata 0x%0h",
                        $time, rsp_tdata);
               fail_count++;
            end else begin
               oldest = expected_writes.pop_front();
               check_field("status", oldest.status, rsp_tuser);
               check_field("byte_offset", oldest.byte_offset, rsp_tdata[23:0]);
               check_field("bit_mask", oldest.bit_mask, rsp_tdata[31:24]);
               check_field("write_bits", oldest.write_bits, rsp_tdata[39:32]);
               check_field("plane_enable", oldest.plane_enable, rsp_tdata[47:40]);
               check_field("plane_set", oldest.plane_set, rsp_tdata[55:48]);
               checked++;
            end
         end
         pending <= expected_writes.size();
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (fbpwa_pkg::reg_index_type'(csr_paddr[4:2]))
               fbpwa_pkg::REG_ENABLED:         mode_enabled    <= csr_pwdata[0];
               fbpwa_pkg::REG_MEMORY_LAYOUT:
                  mode_layout <= fbpwa_pkg::layout_type'(csr_pwdata[1:0]);
               fbpwa_pkg::REG_SCREEN_WIDTH:    mode_width      <= csr_pwdata[11:0];
               fbpwa_pkg::REG_SCREEN_HEIGHT:   mode_height     <= csr_pwdata[11:0];
               fbpwa_pkg::REG_ROW_PITCH:       mode_pitch      <= csr_pwdata[12:0];
               fbpwa_pkg::REG_ODD_BANK_OFFSET: mode_odd_bank   <= csr_pwdata[15:0];
               fbpwa_pkg::REG_BANK_INTERLEAVE: mode_interleave <= csr_pwdata[1:0];
               fbpwa_pkg::REG_PLANE_COUNT:     mode_planes     <= csr_pwdata[3:0];
               default: ;
            endcase
         end
      end
   end

endmodule

@@ sim/tb_framebuffer_pixel_write_address_unit.sv @@
// Testbench top: drives pixels and mode writes into the address unit and reports the verdict.
`timescale 1ns / 1ps

module tb_framebuffer_pixel_write_address_unit;

   // cycles without any accepted transaction before the run is declared hung
   localparam int unsigned StallLimit = 2000;
   localparam int unsigned PixelTarget = 1750;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;

   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   // tdata: pixel_x [10:0], pixel_y [21:11], color_index [29:22], zero [31:30]
   logic [fbpwa_pkg::ReqDataWidth-1:0] req_tdata = '0;

   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   // tdata: byte_offset [23:0], bit_mask [31:24], write_bits [39:32],
   //        plane_enable [47:40], plane_set [55:48]
   logic [fbpwa_pkg::RspDataWidth-1:0] rsp_tdata;
   // tuser: status [1:0]
   logic [fbpwa_pkg::RspUserWidth-1:0] rsp_tuser;

   logic                               csr_psel    = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite  = 1'b0;
   logic [fbpwa_pkg::CsrAddrWidth-1:0] csr_paddr   = '0;
   logic [fbpwa_pkg::CsrDataWidth-1:0] csr_pwdata  = '0;
   logic [fbpwa_pkg::CsrDataWidth-1:0] csr_prdata;
   logic                               csr_pready;

   int          fail_count;
   int          pending;
   int          checked;

   // calm: both sides run without idle cycles for one whole setup
   logic        calm = 1'b0;
   int unsigned idle_cycles = 0;
   int unsigned pixels_sent = 0;
   int unsigned setups = 0;

   // geometry of the current mode, used to aim most random pixels on screen
   int unsigned cur_width  = 320;
   int unsigned cur_height = 200;

   framebuffer_pixel_write_address_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   fbpwa_write_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending),
      .checked     (checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Response side backpressure: ~23% stall, none while calm.
   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 23);
   end

   // Watchdog on forward progress: any handshake on any channel resets it.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("%0t: no transaction for %0d cycles", $time, StallLimit);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // One APB write: setup cycle, then access cycle held until pready.
   task automatic write_reg(fbpwa_pkg::reg_index_type idx,
                            logic [fbpwa_pkg::CsrDataWidth-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // One pixel transaction. tvalid stays high into the next call unless it idles.
   task automatic send_pixel(logic [10:0] x, logic [10:0] y, logic [7:0] color);
      while (!calm && $urandom_range(99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, color, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pixels_sent++;
   endtask

   // Stop sending and let the pipeline empty before touching the mode registers.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Register value biased toward the ends of its legal range and of its field.
   function automatic int unsigned reg_value(int unsigned lo, int unsigned hi,
                                             int unsigned field_max);
      int unsigned r;
      r = $urandom_range(15);
      case (r)
         0:       return lo;
         1:       return hi;
         2:       return field_max;
         3:       return 0;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   // Mostly on-screen coordinates; the rest anywhere in the 11-bit field.
   function automatic logic [10:0] coord_for(int unsigned extent);
      int unsigned top;
      top = (extent > 2048) ? 2048 : extent;
      if (top != 0 && $urandom_range(99) < 85) begin
         return 11'($urandom_range(top - 1, 0));
      end
      return 11'($urandom);
   endfunction

   task automatic random_setup();
      cur_width  = reg_value(1, 2048, 4095);
      cur_height = reg_value(1, 2048, 4095);
      write_reg(fbpwa_pkg::REG_ENABLED, reg_value(1, 1, 1));
      write_reg(fbpwa_pkg::REG_MEMORY_LAYOUT, $urandom_range(3));
      write_reg(fbpwa_pkg::REG_SCREEN_WIDTH, cur_width);
      write_reg(fbpwa_pkg::REG_SCREEN_HEIGHT, cur_height);
      write_reg(fbpwa_pkg::REG_ROW_PITCH, reg_value(1, 4096, 8191));
      write_reg(fbpwa_pkg::REG_ODD_BANK_OFFSET, reg_value(0, 65535, 65535));
      write_reg(fbpwa_pkg::REG_BANK_INTERLEAVE, reg_value(1, 2, 3));
      write_reg(fbpwa_pkg::REG_PLANE_COUNT, reg_value(1, 8, 15));
      setups++;
   endtask

   initial begin
      int unsigned burst;
      int unsigned n;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset the block is disabled: refusal wins over the bounds check.
      send_pixel(11'd0, 11'd0, 8'h00);
      send_pixel(11'd2047, 11'd2047, 8'hFF);
      drain();

      // Enabled with the reset geometry (linear 320x200): corners and both bounds.
      write_reg(fbpwa_pkg::REG_ENABLED, 1);
      setups++;
      send_pixel(11'd0, 11'd0, 8'h5A);
      send_pixel(11'd319, 11'd199, 8'hFF);
      send_pixel(11'd320, 11'd0, 8'h01);
      send_pixel(11'd0, 11'd200, 8'h02);
      send_pixel(11'd2047, 11'd2047, 8'h00);
      drain();

      // Banked at the largest legal geometry.
      write_reg(fbpwa_pkg::REG_MEMORY_LAYOUT, fbpwa_pkg::LAYOUT_BANKED);
      write_reg(fbpwa_pkg::REG_SCREEN_WIDTH, 2048);
      write_reg(fbpwa_pkg::REG_SCREEN_HEIGHT, 2048);
      write_reg(fbpwa_pkg::REG_ROW_PITCH, 4096);
      setups++;
      send_pixel(11'd2047, 11'd2047, 8'hA5);
      send_pixel(11'd1, 11'd0, 8'h3C);
      drain();

      // Interleaved, zero interleave taken as one, widest pitch and bank:
      // the bottom-right pixel pushes the offset past 24 bits.
      write_reg(fbpwa_pkg::REG_MEMORY_LAYOUT, fbpwa_pkg::LAYOUT_INTERLEAVED);
      write_reg(fbpwa_pkg::REG_SCREEN_WIDTH, 4095);
      write_reg(fbpwa_pkg::REG_SCREEN_HEIGHT, 4095);
      write_reg(fbpwa_pkg::REG_ROW_PITCH, 8191);
      write_reg(fbpwa_pkg::REG_ODD_BANK_OFFSET, 65535);
      write_reg(fbpwa_pkg::REG_BANK_INTERLEAVE, 0);
      setups++;
      send_pixel(11'd2047, 11'd2047, 8'h03);
      send_pixel(11'd1, 11'd1, 8'h02);
      send_pixel(11'd2, 11'd0, 8'h01);
      send_pixel(11'd3, 11'd2, 8'hFF);
      drain();

      // Interleave of three divides rows by three.
      write_reg(fbpwa_pkg::REG_BANK_INTERLEAVE, 3);
      setups++;
      send_pixel(11'd5, 11'd7, 8'h01);
      send_pixel(11'd6, 11'd2046, 8'h02);
      drain();

      // Planar: plane count above the maximum saturates, zero enables nothing.
      write_reg(fbpwa_pkg::REG_MEMORY_LAYOUT, fbpwa_pkg::LAYOUT_PLANAR);
      write_reg(fbpwa_pkg::REG_PLANE_COUNT, 15);
      setups++;
      send_pixel(11'd7, 11'd3, 8'hC3);
      send_pixel(11'd0, 11'd0, 8'hFF);
      drain();
      write_reg(fbpwa_pkg::REG_PLANE_COUNT, 0);
      setups++;
      send_pixel(11'd9, 11'd1, 8'hFF);
      drain();

      // Zero width, then zero height: every pixel is off screen.
      write_reg(fbpwa_pkg::REG_SCREEN_WIDTH, 0);
      setups++;
      send_pixel(11'd0, 11'd0, 8'h01);
      drain();
      write_reg(fbpwa_pkg::REG_SCREEN_WIDTH, 1);
      write_reg(fbpwa_pkg::REG_SCREEN_HEIGHT, 0);
      setups++;
      send_pixel(11'd0, 11'd0, 8'h01);
      drain();

      // Random part: bursts of pixels under random mode settings.
      // The fourth burst runs with no idling on either side.
      n = 0;
      while (pixels_sent < PixelTarget) begin
         random_setup();
         calm  = (n == 3);
         burst = $urandom_range(170, 80);
         repeat (burst) begin
            if ($urandom_range(9) == 0) begin
               send_pixel(11'($urandom), 11'($urandom), 8'($urandom));
            end else begin
               send_pixel(coord_for(cur_width), coord_for(cur_height),
                          8'($urandom_range(255)));
            end
         end
         drain();
         calm = 1'b0;
         n++;
      end

      // Pipeline is three deep; a few more cycles catch any stray response.
      repeat (8) @(posedge clock);

      $display("Covered %0d pixel writes (%0d responses checked) over %0d mode setups,",
               pixels_sent, checked, setups);
      $display("spanning all four layouts, disabled and off-screen pixels.");
      if (fail_count == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
